>>> sv/uartto_pkg.sv
// ----------------------------------------------------------------------------
// uartto_pkg
// Shared types and constants for the 8N1 UART with start and stop timeouts.
// ----------------------------------------------------------------------------
package uartto_pkg;

	localparam int CPB_W     = 16;
	localparam int TMO_W     = 32;
	localparam int RX_CNT_W  = 17;
	localparam int TX_FRAME_W = 10;
	localparam int TX_BITS_W = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_CYCLES_PER_BIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS  = 1'd1;

	localparam logic [CPB_W-1:0] CPB_RESET     = 16'd6076;
	localparam logic [TMO_W-1:0] TMO_NEVER     = 32'hFFFF_FFFF;
	localparam logic [TX_BITS_W-1:0] TX_FRAME_BITS = 4'd10;

	localparam logic [1:0] RX_EV_NONE      = 2'd0;
	localparam logic [1:0] RX_EV_BYTE      = 2'd1;
	localparam logic [1:0] RX_EV_START_TMO = 2'd2;
	localparam logic [1:0] RX_EV_STOP_TMO  = 2'd3;

	localparam logic [1:0] RX_IDLE = 2'd0;
	localparam logic [1:0] RX_DATA = 2'd1;
	localparam logic [1:0] RX_STOP = 2'd2;

	typedef struct packed {
		logic tx_line;
		logic tx_busy;
		logic send_accepted;
	} tx_res_t;

	typedef struct packed {
		logic [1:0] rx_event;
		logic [7:0] rx_byte;
	} rx_res_t;

endpackage

>>> sv/uartto_tx.sv
// ----------------------------------------------------------------------------
// uartto_tx
// 8N1 transmitter; its bit timer advances one tick per stepped item.
// ----------------------------------------------------------------------------
module uartto_tx import uartto_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             send_valid,
	input  logic [7:0]       send_byte,
	input  logic [CPB_W-1:0] cycles_per_bit,
	output tx_res_t          res
);

	logic [TX_FRAME_W-1:0] shift_q, shift_a, shift_d;
	logic [TX_BITS_W-1:0]  bits_left_q, bits_left_a, bits_left_d;
	logic [CPB_W-1:0]      tick_q, tick_a, tick_inc, tick_d;
	logic                  acc, busy;

	always_comb begin
		acc         = send_valid && (bits_left_q == '0);
		shift_a     = acc ? {1'b1, send_byte, 1'b0} : shift_q;
		bits_left_a = acc ? TX_FRAME_BITS : bits_left_q;
		tick_a      = acc ? '0 : tick_q;
		busy        = bits_left_a != '0;
		tick_inc    = tick_a + 1'b1;
		shift_d     = shift_a;
		bits_left_d = bits_left_a;
		tick_d      = tick_a;
		if (busy) begin
			if (tick_inc >= cycles_per_bit) begin
				shift_d     = {1'b1, shift_a[TX_FRAME_W-1:1]};
				bits_left_d = bits_left_a - 1'b1;
				tick_d      = '0;
			end else begin
				tick_d = tick_inc;
			end
		end
		res.tx_line       = busy ? shift_a[0] : 1'b1;
		res.tx_busy       = busy;
		res.send_accepted = acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q     <= '1;
			bits_left_q <= '0;
			tick_q      <= '0;
		end else if (step) begin
			shift_q     <= shift_d;
			bits_left_q <= bits_left_d;
			tick_q      <= tick_d;
		end
	end

endmodule

>>> sv/uartto_rx.sv
// ----------------------------------------------------------------------------
// uartto_rx
// 8N1 receiver with start-bit and stop-bit timeouts.
// ----------------------------------------------------------------------------
module uartto_rx import uartto_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             rx_level,
	input  logic [CPB_W-1:0] cycles_per_bit,
	input  logic [TMO_W-1:0] timeout_ticks,
	output rx_res_t          res
);

	logic [1:0]          mode_q, mode_d;
	logic [RX_CNT_W-1:0] tick_q, tick_d, tick_inc, target;
	logic [2:0]          idx_q, idx_d;
	logic [7:0]          shift_q, shift_d;
	logic [TMO_W-1:0]    wait_q, wait_d;
	logic                expired;
	logic [TMO_W-1:0]    wait_exp;

	always_comb begin
		if (timeout_ticks == TMO_NEVER) begin
			expired  = 1'b0;
			wait_exp = wait_q;
		end else if (wait_q >= timeout_ticks) begin
			expired  = 1'b1;
			wait_exp = '0;
		end else begin
			expired  = 1'b0;
			wait_exp = wait_q + 1'b1;
		end

		target   = (idx_q == '0)
			? ({1'b0, cycles_per_bit} + {2'b00, cycles_per_bit[CPB_W-1:1]})
			: {1'b0, cycles_per_bit};
		tick_inc = tick_q + 1'b1;

		mode_d      = mode_q;
		tick_d      = tick_q;
		idx_d       = idx_q;
		shift_d     = shift_q;
		wait_d      = wait_q;
		res.rx_event = RX_EV_NONE;
		res.rx_byte  = '0;

		case (mode_q)
			RX_DATA: begin
				if (tick_inc >= target) begin
					shift_d        = shift_q;
					shift_d[idx_q] = shift_q[idx_q] | rx_level;
					tick_d         = '0;
					if (idx_q == 3'd7) begin
						idx_d  = '0;
						mode_d = RX_STOP;
						wait_d = '0;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end else begin
					tick_d = tick_inc;
				end
			end
			RX_STOP: begin
				if (rx_level) begin
					res.rx_event = RX_EV_BYTE;
					res.rx_byte  = shift_q;
					mode_d       = RX_IDLE;
					wait_d       = '0;
				end else if (expired) begin
					res.rx_event = RX_EV_STOP_TMO;
					mode_d       = RX_IDLE;
					wait_d       = '0;
				end else begin
					wait_d = wait_exp;
				end
			end
			default: begin
				mode_d = RX_IDLE;
				if (!rx_level) begin
					mode_d  = RX_DATA;
					tick_d  = '0;
					idx_d   = '0;
					shift_d = '0;
					wait_d  = '0;
				end else begin
					wait_d = wait_exp;
					if (expired) begin
						res.rx_event = RX_EV_START_TMO;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= RX_IDLE;
			tick_q  <= '0;
			idx_q   <= '0;
			shift_q <= '0;
			wait_q  <= '0;
		end else if (step) begin
			mode_q  <= mode_d;
			tick_q  <= tick_d;
			idx_q   <= idx_d;
			shift_q <= shift_d;
			wait_q  <= wait_d;
		end
	end

endmodule

>>> sv/uart_tx_rx_with_timeout_top.sv
// ----------------------------------------------------------------------------
// uart_tx_rx_with_timeout_top
// 8N1 UART transmitter and receiver, one stream transaction per clock tick.
//
// Each input transaction is one tick of the bit timer: it carries the sampled
// receive level, a send request flag (s_tuser) and the byte to send. Every
// input transaction yields exactly one output transaction with the transmit
// line level, busy and accept flags, and the receive event (m_tuser) with the
// received byte.
// A transaction passes through the input register and then the result register
// before output valid. Throughput is one transaction per cycle while the
// output is not stalled, set by the state update between the two registers.
// A stalled output holds the result register and, once the input register is
// full, deasserts s_tready; no transaction is lost or repeated.
// Reset clears both stages, idles the transmitter and receiver and loads
// cycles_per_bit 6076 and timeout_ticks all ones (no timeout). Write the
// configuration channel only while no transaction is in flight.
// ----------------------------------------------------------------------------
module uart_tx_rx_with_timeout_top import uartto_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [15:0]           s_tdata,  // rx_level, send_byte[7:0], zero pad
	input  logic                  s_tuser,  // send_valid
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata,  // tx_line, tx_busy, send_accepted, rx_byte[7:0], pad
	output logic [1:0]            m_tuser,  // rx_event[1:0]
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic             in_valid_s1;
	logic             rx_level_s1;
	logic             send_valid_s1;
	logic [7:0]       send_byte_s1;
	logic             advance;
	logic [CPB_W-1:0] cpb_q;
	logic [TMO_W-1:0] tmo_q;
	tx_res_t          tx_res;
	rx_res_t          rx_res;
	logic             out_valid_s2;
	tx_res_t          tx_res_s2;
	rx_res_t          rx_res_s2;

	assign advance   = in_valid_s1 && (!out_valid_s2 || m_tready);
	assign s_tready  = !in_valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpb_q <= CPB_RESET;
			tmo_q <= TMO_NEVER;
		end else if (cfg_valid) begin
			case (cfg_addr)
				CFG_CYCLES_PER_BIT: cpb_q <= cfg_data[CPB_W-1:0];
				CFG_TIMEOUT_TICKS:  tmo_q <= cfg_data[TMO_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			rx_level_s1   <= s_tdata[0];
			send_byte_s1  <= s_tdata[8:1];
			send_valid_s1 <= s_tuser;
		end
	end

	uartto_tx u_tx (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.send_valid     (send_valid_s1),
		.send_byte      (send_byte_s1),
		.cycles_per_bit (cpb_q),
		.res            (tx_res)
	);

	uartto_rx u_rx (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.rx_level       (rx_level_s1),
		.cycles_per_bit (cpb_q),
		.timeout_ticks  (tmo_q),
		.res            (rx_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tx_res_s2 <= tx_res;
			rx_res_s2 <= rx_res;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = {5'd0, rx_res_s2.rx_byte, tx_res_s2.send_accepted,
		tx_res_s2.tx_busy, tx_res_s2.tx_line};
	assign m_tuser  = rx_res_s2.rx_event;

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the 8N1 UART with start and stop timeouts.
//
// Each input transaction is one bit-timer tick. The bench sends serial frames
// on the receive level (well formed, with broken stop bits, idle runs and
// glitches) together with random send requests. It predicts every output
// transaction from its own model of the transmitter and the receiver. Both
// stream sides stall at random. Configuration changes happen between phases,
// once the output stream has drained.
// ----------------------------------------------------------------------------
module testbench import uartto_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 500000;

	typedef struct packed {
		tx_res_t tx;
		rx_res_t rx;
	} uart_tick_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [15:0]           s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [15:0]           m_tdata;
	logic [1:0]            m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	uart_tx_rx_with_timeout_top u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state and its copy of the registers
	logic [CPB_W-1:0]      bit_period;
	logic [TMO_W-1:0]      timeout_lim;
	logic [TX_FRAME_W-1:0] tx_frame;
	logic [TX_BITS_W-1:0]  tx_left;
	logic [CPB_W-1:0]      tx_ticks;
	logic [1:0]            rx_state;
	logic [RX_CNT_W-1:0]   rx_ticks;
	logic [2:0]            rx_idx;
	logic [7:0]            rx_data;
	logic [31:0]           idle_wait;

	uart_tick_t awaited_outputs[$];
	int         err_count = 0;
	int         items_sent = 0;
	int         cycles = 0;
	int         stall_left = 0;
	bit         idle_on = 1'b1;

	function automatic void reset_model();
		bit_period  = CPB_RESET;
		timeout_lim = TMO_NEVER;
		tx_frame    = '1;
		tx_left     = '0;
		tx_ticks    = '0;
		rx_state    = RX_IDLE;
		rx_ticks    = '0;
		rx_idx      = '0;
		rx_data     = '0;
		idle_wait   = '0;
	endfunction

	function automatic bit wait_timed_out();
		if (timeout_lim == TMO_NEVER)
			return 1'b0;
		if (idle_wait >= timeout_lim) begin
			idle_wait = '0;
			return 1'b1;
		end
		idle_wait++;
		return 1'b0;
	endfunction

	function automatic uart_tick_t uart_predict(logic lvl, logic req, logic [7:0] sbyte);
		uart_tick_t          r;
		logic [RX_CNT_W-1:0] target;
		r.tx = '0;
		r.rx = '0;
		if (req && tx_left == 0) begin
			r.tx.send_accepted = 1'b1;
			tx_frame = {1'b1, sbyte, 1'b0};
			tx_left  = TX_FRAME_BITS;
			tx_ticks = '0;
		end
		r.tx.tx_busy = (tx_left != 0);
		r.tx.tx_line = r.tx.tx_busy ? tx_frame[0] : 1'b1;
		if (r.tx.tx_busy) begin
			tx_ticks = tx_ticks + 1'b1;
			if (tx_ticks >= bit_period) begin
				tx_frame = {1'b1, tx_frame[TX_FRAME_W-1:1]};
				tx_left  = tx_left - 1'b1;
				tx_ticks = '0;
			end
		end
		case (rx_state)
			RX_DATA: begin
				target = (rx_idx == 0) ? {1'b0, bit_period} + (bit_period >> 1)
				                       : {1'b0, bit_period};
				rx_ticks = rx_ticks + 1'b1;
				if (rx_ticks >= target) begin
					rx_data[rx_idx] = rx_data[rx_idx] | lvl;
					rx_ticks = '0;
					if (rx_idx == 3'd7) begin
						rx_idx    = '0;
						rx_state  = RX_STOP;
						idle_wait = '0;
					end else begin
						rx_idx = rx_idx + 1'b1;
					end
				end
			end
			RX_STOP: begin
				if (lvl) begin
					r.rx.rx_event = RX_EV_BYTE;
					r.rx.rx_byte  = rx_data;
					rx_state      = RX_IDLE;
					idle_wait     = '0;
				end else if (wait_timed_out()) begin
					r.rx.rx_event = RX_EV_STOP_TMO;
					rx_state      = RX_IDLE;
					idle_wait     = '0;
				end
			end
			default: begin
				rx_state = RX_IDLE;
				if (!lvl) begin
					rx_state  = RX_DATA;
					rx_ticks  = '0;
					rx_idx    = '0;
					rx_data   = '0;
					idle_wait = '0;
				end else if (wait_timed_out()) begin
					r.rx.rx_event = RX_EV_START_TMO;
				end
			end
		endcase
		return r;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 99) < 80)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// extra ticks so idle runs and low stop bits can outlast a short timeout
	function automatic int tmo_slack();
		return (timeout_lim < 40) ? int'(timeout_lim) : 40;
	endfunction

	task automatic report_mismatch(input string what, input int want_v, input int got_v);
		err_count++;
		$display("[%0t] %s: expected %0d, got %0d", $time, what, want_v, got_v);
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
			if (idle_on && $urandom_range(0, 9) == 0)
				stall_left = gap_len();
		end
	end

	// values at the falling edge hold through the next rising edge
	always @(negedge clk) begin : check_results
		uart_tick_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_outputs.size() == 0) begin
				report_mismatch("output transaction with none pending", 0, 1);
			end else begin
				want = awaited_outputs.pop_front();
				if (m_tdata[0] !== want.tx.tx_line)
					report_mismatch("tx_line", want.tx.tx_line, m_tdata[0]);
				if (m_tdata[1] !== want.tx.tx_busy)
					report_mismatch("tx_busy", want.tx.tx_busy, m_tdata[1]);
				if (m_tdata[2] !== want.tx.send_accepted)
					report_mismatch("send_accepted", want.tx.send_accepted, m_tdata[2]);
				if (m_tuser !== want.rx.rx_event)
					report_mismatch("rx_event", want.rx.rx_event, m_tuser);
				if (m_tdata[10:3] !== want.rx.rx_byte)
					report_mismatch("rx_byte", want.rx.rx_byte, m_tdata[10:3]);
			end
		end
	end

	task automatic send_tick(input logic lvl, input logic req, input logic [7:0] sbyte);
		int gap;
		bit ok;
		gap = (idle_on && $urandom_range(0, 3) == 0) ? gap_len() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, sbyte, lvl};
		s_tuser  <= req;
		do begin
			@(negedge clk);
			ok = s_tready;
			@(posedge clk);
		end while (!ok);
		awaited_outputs.push_back(uart_predict(lvl, req, sbyte));
		items_sent++;
	endtask

	task automatic line_tick(input logic lvl);
		send_tick(lvl, $urandom_range(0, 7) == 0, 8'($urandom));
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (awaited_outputs.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		bit ok;
		wait_drain();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_addr  <= idx;
		cfg_data  <= val;
		do begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
		end while (!ok);
		cfg_valid <= 1'b0;
		if (idx == CFG_CYCLES_PER_BIT)
			bit_period = val[CPB_W-1:0];
		else
			timeout_lim = val[TMO_W-1:0];
	endtask

	task automatic rx_frame(input logic [7:0] data, input bit stop_ok);
		int blen;
		blen = (bit_period < 2) ? 1 : int'(bit_period);
		repeat (blen) line_tick(1'b0);
		for (int i = 0; i < 8; i++)
			repeat (blen) line_tick(data[i]);
		if (!stop_ok)
			repeat ($urandom_range(1, 2 * blen + 4 + tmo_slack())) line_tick(1'b0);
		repeat (blen + $urandom_range(0, blen)) line_tick(1'b1);
	endtask

	// one tick per bit: start, data LSB first, then the given stop level
	task automatic directed_frame(input logic [7:0] data, input logic stop_lvl,
	                              input logic [7:0] sbyte);
		logic [9:0] bits;
		bits = {stop_lvl, data, 1'b0};
		for (int i = 0; i < 10; i++)
			send_tick(bits[i], i == 9, sbyte);
	endtask

	task automatic test_reset_defaults();
		idle_on = 1'b0;
		send_tick(1'b1, 1'b1, 8'h00);
		send_tick(1'b0, 1'b1, 8'hFF);
		send_tick(1'b1, 1'b0, 8'hFF);
		send_tick(1'b1, 1'b1, 8'h00);
	endtask

	task automatic test_tiny_period();
		write_reg(CFG_CYCLES_PER_BIT, 32'd1);
		write_reg(CFG_TIMEOUT_TICKS, 32'd0);
		send_tick(1'b1, 1'b0, 8'h00);
		send_tick(1'b1, 1'b0, 8'h00);
		directed_frame(8'hA5, 1'b1, 8'hFF);
		directed_frame(8'h5A, 1'b0, 8'h00);
		send_tick(1'b1, 1'b1, 8'h81);
	endtask

	task automatic test_random_traffic(input logic [CPB_W-1:0] cpb, input logic [TMO_W-1:0] tmo,
	                                   input int budget);
		int  first;
		int  blen;
		int  pick;
		bit  paused;
		write_reg(CFG_CYCLES_PER_BIT, CFG_DATA_W'(cpb));
		write_reg(CFG_TIMEOUT_TICKS, tmo);
		idle_on = ($urandom_range(0, 3) != 0);
		first   = items_sent;
		paused  = 1'b0;
		blen    = (cpb < 2) ? 1 : int'(cpb);
		while (items_sent - first < budget) begin
			pick = $urandom_range(0, 99);
			if (blen <= 64 && pick < 70)
				rx_frame(8'($urandom), $urandom_range(0, 4) != 0);
			else if (pick < 85)
				repeat ($urandom_range(1, (blen <= 64 ? 3 * blen : 20) + tmo_slack()))
					line_tick(1'b1);
			else
				repeat ($urandom_range(1, 12)) line_tick(1'($urandom));
			if (!paused && items_sent - first >= budget / 2) begin
				wait_drain();
				paused = 1'b1;
			end
			if ($urandom_range(0, 9) == 0)
				idle_on = !idle_on;
		end
	endtask

	initial begin
		reset_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_tiny_period();
		test_random_traffic(16'd2, 32'd3, 110);
		test_random_traffic(16'd0, 32'd2, 60);
		test_random_traffic(16'd3, TMO_NEVER, 110);
		test_random_traffic(16'd4, 32'd0, 100);
		test_random_traffic(16'd5, 32'd25, 110);
		test_random_traffic(16'd65535, 32'd5, 40);
		test_random_traffic(16'd2, 32'hFFFF_FFFE, 100);
		test_random_traffic(16'd6, 32'd12, 110);
		test_random_traffic(16'd3, 32'd1, 100);
		wait_drain();
		repeat (8) @(posedge clk);
		if (err_count == 0 && awaited_outputs.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
